[hdl/vrrl_pkg.sv]
// ----------------------------------------------------------------------------
// vrrl_pkg
// Shared item types, mode and status codes, header offsets and the
// controller-to-datapath command and status types of the ring log.
// ----------------------------------------------------------------------------
package vrrl_pkg;

  localparam int LEN_W  = 12;
  localparam int SIZE_W = 13;
  localparam int HOFS_W = 5;

  typedef struct packed {
    logic [2:0]       mode;
    logic [63:0]      stamp;
    logic [63:0]      run_id;
    logic [7:0]       level;
    logic [LEN_W-1:0] message_length;
    logic [7:0]       data_in;
    logic             select_all;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [63:0]      stamp_out;
    logic [7:0]       level_out;
    logic [LEN_W-1:0] length_out;
    logic [7:0]       data_out;
    logic             last_byte;
    logic [7:0]       evicted;
  } out_item_t;

  localparam logic [2:0] MODE_PUSH_START = 3'd0;
  localparam logic [2:0] MODE_PUSH_BYTE  = 3'd1;
  localparam logic [2:0] MODE_DISCARD    = 3'd2;
  localparam logic [2:0] MODE_SCAN_BEGIN = 3'd3;
  localparam logic [2:0] MODE_SCAN_NEXT  = 3'd4;
  localparam logic [2:0] MODE_READ_BYTE  = 3'd5;
  localparam logic [2:0] MODE_CLEAR      = 3'd6;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TOO_BIG = 2'd1;
  localparam logic [1:0] ST_ENDED   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // header byte offsets, little-endian fields
  localparam logic [HOFS_W-1:0] OFS_ID     = 5'd8;
  localparam logic [HOFS_W-1:0] OFS_LEN    = 5'd16;
  localparam logic [HOFS_W-1:0] OFS_LEN_HI = 5'd17;
  localparam logic [HOFS_W-1:0] OFS_LEVEL  = 5'd18;
  localparam logic [HOFS_W-1:0] OFS_MARK   = 5'd19;

  typedef enum logic [4:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_STAT_IGNORED,
    ACT_DROP_START,
    ACT_HRD_OLDEST,
    ACT_HRD_BASE,
    ACT_HRD_SCAN,
    ACT_HRD,
    ACT_EV_APPLY,
    ACT_EV_END,
    ACT_HWR,
    ACT_PUSH_COMMIT,
    ACT_BYTE,
    ACT_DISC_INIT,
    ACT_DISC_APPLY,
    ACT_SCAN_BEGIN,
    ACT_SCAN_APPLY,
    ACT_SCAN_END,
    ACT_RD_ISSUE,
    ACT_RD_DONE,
    ACT_CLEAR,
    ACT_LOAD_OUT
  } act_e;

  typedef struct packed {
    logic [2:0] mode;
    logic       push_busy;
    logic       too_big;
    logic       need_evict;
    logic       walk_more;
    logic       found;
    logic       hrd_last;
    logic       hwr_last;
    logic       scan_active;
    logic       read_empty;
    logic       out_free;
  } dp_stat_t;

endpackage

[hdl/vrrl_ctrl.sv]
// ----------------------------------------------------------------------------
// vrrl_ctrl
// Sequencer: decodes the held item and steps the datapath through header
// reads, evictions, header writes, discard and scan walks.
// ----------------------------------------------------------------------------
module vrrl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vrrl_pkg::dp_stat_t stat_i,
  output vrrl_pkg::act_e     act_o
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_DECODE   = 12'b0000_0000_0010,
    S_EV_CHK   = 12'b0000_0000_0100,
    S_HRD      = 12'b0000_0000_1000,
    S_HRD_WAIT = 12'b0000_0001_0000,
    S_APPLY    = 12'b0000_0010_0000,
    S_HWR      = 12'b0000_0100_0000,
    S_COMMIT   = 12'b0000_1000_0000,
    S_DISC_CHK = 12'b0001_0000_0000,
    S_SCAN_CHK = 12'b0010_0000_0000,
    S_RD_WAIT  = 12'b0100_0000_0000,
    S_FINISH   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    act_o   = vrrl_pkg::ACT_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_o   = vrrl_pkg::ACT_ACCEPT;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        case (stat_i.mode)
          vrrl_pkg::MODE_PUSH_START: begin
            if (stat_i.push_busy) begin
              act_o = vrrl_pkg::ACT_STAT_IGNORED;
            end else if (stat_i.too_big) begin
              act_o = vrrl_pkg::ACT_DROP_START;
            end else begin
              state_d = S_EV_CHK;
            end
          end
          vrrl_pkg::MODE_PUSH_BYTE: act_o = vrrl_pkg::ACT_BYTE;
          vrrl_pkg::MODE_DISCARD: begin
            act_o   = vrrl_pkg::ACT_DISC_INIT;
            state_d = S_DISC_CHK;
          end
          vrrl_pkg::MODE_SCAN_BEGIN: act_o = vrrl_pkg::ACT_SCAN_BEGIN;
          vrrl_pkg::MODE_SCAN_NEXT: begin
            if (!stat_i.scan_active) begin
              act_o = vrrl_pkg::ACT_STAT_IGNORED;
            end else begin
              state_d = S_SCAN_CHK;
            end
          end
          vrrl_pkg::MODE_READ_BYTE: begin
            act_o = vrrl_pkg::ACT_RD_ISSUE;
            if (!stat_i.read_empty) state_d = S_RD_WAIT;
          end
          vrrl_pkg::MODE_CLEAR: act_o = vrrl_pkg::ACT_CLEAR;
          default: act_o = vrrl_pkg::ACT_STAT_IGNORED;
        endcase
      end
      S_EV_CHK: begin
        if (stat_i.need_evict) begin
          act_o   = vrrl_pkg::ACT_HRD_OLDEST;
          state_d = S_HRD;
        end else begin
          act_o   = vrrl_pkg::ACT_EV_END;
          state_d = S_HWR;
        end
      end
      S_HRD: begin
        act_o = vrrl_pkg::ACT_HRD;
        if (stat_i.hrd_last) state_d = S_HRD_WAIT;
      end
      S_HRD_WAIT: state_d = S_APPLY;
      S_APPLY: begin
        case (stat_i.mode)
          vrrl_pkg::MODE_PUSH_START: begin
            act_o   = vrrl_pkg::ACT_EV_APPLY;
            state_d = S_EV_CHK;
          end
          vrrl_pkg::MODE_DISCARD: begin
            act_o   = vrrl_pkg::ACT_DISC_APPLY;
            state_d = S_DISC_CHK;
          end
          default: begin
            act_o   = vrrl_pkg::ACT_SCAN_APPLY;
            state_d = stat_i.found ? S_FINISH : S_SCAN_CHK;
          end
        endcase
      end
      S_HWR: begin
        act_o = vrrl_pkg::ACT_HWR;
        if (stat_i.hwr_last) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        act_o   = vrrl_pkg::ACT_PUSH_COMMIT;
        state_d = S_FINISH;
      end
      S_DISC_CHK: begin
        if (stat_i.walk_more) begin
          act_o   = vrrl_pkg::ACT_HRD_BASE;
          state_d = S_HRD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SCAN_CHK: begin
        if (stat_i.walk_more) begin
          act_o   = vrrl_pkg::ACT_HRD_SCAN;
          state_d = S_HRD;
        end else begin
          act_o   = vrrl_pkg::ACT_SCAN_END;
          state_d = S_FINISH;
        end
      end
      S_RD_WAIT: begin
        act_o   = vrrl_pkg::ACT_RD_DONE;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          act_o   = vrrl_pkg::ACT_LOAD_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/vrrl_dp.sv]
// ----------------------------------------------------------------------------
// vrrl_dp
// Datapath: byte ring memory, ring pointers, push/scan/read state, header
// capture registers, result and output registers.
// ----------------------------------------------------------------------------
module vrrl_dp #(
  parameter int RING_BYTES          = 4096,
  parameter int RECORD_HEADER_BYTES = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vrrl_pkg::in_item_t  in_item_i,
  input  vrrl_pkg::act_e      act_i,
  output vrrl_pkg::dp_stat_t  stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vrrl_pkg::out_item_t out_item_o
);

  localparam int AW = $clog2(RING_BYTES);
  localparam int CW = $clog2(RING_BYTES + 1);
  localparam int XW = (CW > vrrl_pkg::SIZE_W) ? CW : vrrl_pkg::SIZE_W;
  localparam int LW = vrrl_pkg::LEN_W;
  localparam int OW = vrrl_pkg::HOFS_W;
  localparam logic [XW:0] RING_X = (XW + 1)'(RING_BYTES);
  localparam logic [XW:0] HDR_X  = (XW + 1)'(RECORD_HEADER_BYTES);
  localparam logic [OW-1:0] HWR_LAST = OW'(RECORD_HEADER_BYTES - 1);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [XW:0] inc);
    logic [XW:0] s;
    s = (XW + 1)'(p) + inc;
    if (s >= RING_X) s = s - RING_X;
    return s[AW-1:0];
  endfunction

  logic [7:0] mem [RING_BYTES];
  logic [7:0] rdata_q;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, hdr_byte;

  vrrl_pkg::in_item_t  item_q, item_d;
  vrrl_pkg::out_item_t res_q, res_d, out_q, out_d;
  logic          out_vld_q, out_vld_d;
  logic [AW-1:0] oldest_q, oldest_d, wp_q, wp_d, scan_pos_q, scan_pos_d;
  logic [AW-1:0] read_pos_q, read_pos_d, base_q, base_d;
  logic [CW-1:0] used_q, used_d, pending_q, pending_d, scan_done_q, scan_done_d;
  logic [CW-1:0] walk_done_q, walk_done_d;
  logic [LW-1:0] push_left_q, push_left_d, read_left_q, read_left_d;
  logic          dropping_q, dropping_d, all_q, all_d, active_q, active_d;
  logic [63:0]   filter_q, filter_d;
  logic [OW-1:0] off_q, off_d, cap_off_q;
  logic          cap_vld_q;
  logic [7:0]    count_q, count_d;
  logic [63:0]   h_stamp_q, h_stamp_d, h_id_q, h_id_d;
  logic [LW-1:0] h_len_q, h_len_d;
  logic [7:0]    h_level_q, h_level_d, h_mark_q, h_mark_d;

  logic [XW:0] size_x, used_x, rec_x, old_x;
  logic        found;

  assign size_x = HDR_X + (XW + 1)'(item_q.message_length);
  assign used_x = (XW + 1)'(used_q);
  assign rec_x  = HDR_X + (XW + 1)'(h_len_q);
  assign old_x  = (rec_x < used_x) ? rec_x : used_x;
  assign found  = (h_mark_q == 8'd0) && (all_q || (h_id_q == filter_q));

  always_comb begin
    stat_o.mode        = item_q.mode;
    stat_o.push_busy   = (push_left_q != '0);
    stat_o.too_big     = (size_x > RING_X);
    stat_o.need_evict  = ((RING_X - used_x) < size_x) && (used_q != '0);
    stat_o.walk_more   = (item_q.mode == vrrl_pkg::MODE_DISCARD) ?
                         (walk_done_q < used_q) : (scan_done_q < used_q);
    stat_o.found       = found;
    stat_o.hrd_last    = (off_q == vrrl_pkg::OFS_MARK);
    stat_o.hwr_last    = (off_q == HWR_LAST);
    stat_o.scan_active = active_q;
    stat_o.read_empty  = (read_left_q == '0);
    stat_o.out_free    = !out_vld_q || out_ready_i;
  end

  always_comb begin
    if (off_q < vrrl_pkg::OFS_ID) begin
      hdr_byte = item_q.stamp[8*off_q[2:0] +: 8];
    end else if (off_q < vrrl_pkg::OFS_LEN) begin
      hdr_byte = item_q.run_id[8*off_q[2:0] +: 8];
    end else if (off_q == vrrl_pkg::OFS_LEN) begin
      hdr_byte = item_q.message_length[7:0];
    end else if (off_q == vrrl_pkg::OFS_LEN_HI) begin
      hdr_byte = {4'd0, item_q.message_length[LW-1:8]};
    end else if (off_q == vrrl_pkg::OFS_LEVEL) begin
      hdr_byte = item_q.level;
    end else begin
      hdr_byte = 8'd0;
    end
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = wp_q;
    raddr = base_q;
    wdata = hdr_byte;
    case (act_i)
      vrrl_pkg::ACT_HRD: begin
        re    = 1'b1;
        raddr = wrap_add(base_q, (XW + 1)'(off_q));
      end
      vrrl_pkg::ACT_RD_ISSUE: begin
        re    = (read_left_q != '0);
        raddr = read_pos_q;
      end
      vrrl_pkg::ACT_HWR: begin
        we    = 1'b1;
        waddr = wrap_add(wp_q, (XW + 1)'(off_q));
      end
      vrrl_pkg::ACT_BYTE: begin
        we    = (push_left_q != '0) && !dropping_q;
        wdata = item_q.data_in;
      end
      vrrl_pkg::ACT_DISC_APPLY: begin
        we    = (h_id_q == item_q.run_id);
        waddr = wrap_add(base_q, (XW + 1)'(vrrl_pkg::OFS_MARK));
        wdata = 8'd1;
      end
      vrrl_pkg::ACT_SCAN_APPLY: begin
        we    = found && !all_q;
        waddr = wrap_add(base_q, (XW + 1)'(vrrl_pkg::OFS_MARK));
        wdata = 8'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_comb begin
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    oldest_d    = oldest_q;
    wp_d        = wp_q;
    scan_pos_d  = scan_pos_q;
    read_pos_d  = read_pos_q;
    base_d      = base_q;
    used_d      = used_q;
    pending_d   = pending_q;
    scan_done_d = scan_done_q;
    walk_done_d = walk_done_q;
    push_left_d = push_left_q;
    read_left_d = read_left_q;
    dropping_d  = dropping_q;
    all_d       = all_q;
    active_d    = active_q;
    filter_d    = filter_q;
    off_d       = off_q;
    count_d     = count_q;
    h_stamp_d   = h_stamp_q;
    h_id_d      = h_id_q;
    h_len_d     = h_len_q;
    h_level_d   = h_level_q;
    h_mark_d    = h_mark_q;

    if (cap_vld_q) begin
      if (cap_off_q < vrrl_pkg::OFS_ID) begin
        h_stamp_d[8*cap_off_q[2:0] +: 8] = rdata_q;
      end else if (cap_off_q < vrrl_pkg::OFS_LEN) begin
        h_id_d[8*cap_off_q[2:0] +: 8] = rdata_q;
      end else if (cap_off_q == vrrl_pkg::OFS_LEN) begin
        h_len_d[7:0] = rdata_q;
      end else if (cap_off_q == vrrl_pkg::OFS_LEN_HI) begin
        h_len_d[LW-1:8] = rdata_q[LW-9:0];
      end else if (cap_off_q == vrrl_pkg::OFS_LEVEL) begin
        h_level_d = rdata_q;
      end else begin
        h_mark_d = rdata_q;
      end
    end

    case (act_i)
      vrrl_pkg::ACT_ACCEPT: begin
        item_d  = in_item_i;
        res_d   = '0;
        count_d = 8'd0;
      end
      vrrl_pkg::ACT_STAT_IGNORED: res_d.status = vrrl_pkg::ST_IGNORED;
      vrrl_pkg::ACT_DROP_START: begin
        dropping_d   = 1'b1;
        push_left_d  = item_q.message_length;
        res_d.status = vrrl_pkg::ST_TOO_BIG;
      end
      vrrl_pkg::ACT_HRD_OLDEST: begin
        base_d = oldest_q;
        off_d  = '0;
      end
      vrrl_pkg::ACT_HRD_BASE: off_d = '0;
      vrrl_pkg::ACT_HRD_SCAN: begin
        base_d = scan_pos_q;
        off_d  = '0;
      end
      vrrl_pkg::ACT_HRD: off_d = off_q + 1'b1;
      vrrl_pkg::ACT_EV_APPLY: begin
        oldest_d = wrap_add(oldest_q, old_x);
        used_d   = used_q - CW'(old_x);
        if (count_q != 8'hFF) count_d = count_q + 8'd1;
      end
      vrrl_pkg::ACT_EV_END: begin
        if (count_q != 8'd0) begin
          active_d    = 1'b0;
          read_left_d = '0;
        end
        off_d = '0;
      end
      vrrl_pkg::ACT_HWR: off_d = off_q + 1'b1;
      vrrl_pkg::ACT_PUSH_COMMIT: begin
        wp_d = wrap_add(wp_q, HDR_X);
        if (item_q.message_length == '0) begin
          used_d = used_q + CW'(size_x);
        end else begin
          pending_d   = CW'(size_x);
          push_left_d = item_q.message_length;
        end
        res_d.evicted = count_q;
      end
      vrrl_pkg::ACT_BYTE: begin
        if (push_left_q == '0) begin
          res_d.status = vrrl_pkg::ST_IGNORED;
        end else if (dropping_q) begin
          push_left_d  = push_left_q - 1'b1;
          if (push_left_q == LW'(1)) dropping_d = 1'b0;
          res_d.status = vrrl_pkg::ST_TOO_BIG;
        end else begin
          wp_d        = wrap_add(wp_q, (XW + 1)'(1));
          push_left_d = push_left_q - 1'b1;
          if (push_left_q == LW'(1)) used_d = used_q + pending_q;
        end
      end
      vrrl_pkg::ACT_DISC_INIT: begin
        base_d      = oldest_q;
        walk_done_d = '0;
      end
      vrrl_pkg::ACT_DISC_APPLY: begin
        walk_done_d = walk_done_q + CW'(rec_x);
        base_d      = wrap_add(base_q, rec_x);
      end
      vrrl_pkg::ACT_SCAN_BEGIN: begin
        filter_d    = item_q.run_id;
        all_d       = item_q.select_all;
        scan_pos_d  = oldest_q;
        scan_done_d = '0;
        active_d    = 1'b1;
        read_left_d = '0;
      end
      vrrl_pkg::ACT_SCAN_APPLY: begin
        scan_pos_d  = wrap_add(base_q, rec_x);
        scan_done_d = scan_done_q + CW'(rec_x);
        if (found) begin
          res_d.stamp_out  = h_stamp_q;
          res_d.level_out  = h_level_q;
          res_d.length_out = h_len_q;
          read_pos_d       = wrap_add(base_q, HDR_X);
          read_left_d      = h_len_q;
        end
      end
      vrrl_pkg::ACT_SCAN_END: begin
        active_d     = 1'b0;
        read_left_d  = '0;
        res_d.status = vrrl_pkg::ST_ENDED;
      end
      vrrl_pkg::ACT_RD_ISSUE: begin
        if (read_left_q == '0) res_d.status = vrrl_pkg::ST_ENDED;
      end
      vrrl_pkg::ACT_RD_DONE: begin
        res_d.data_out  = rdata_q;
        res_d.last_byte = (read_left_q == LW'(1));
        read_pos_d      = wrap_add(read_pos_q, (XW + 1)'(1));
        read_left_d     = read_left_q - 1'b1;
      end
      vrrl_pkg::ACT_CLEAR: begin
        oldest_d    = '0;
        wp_d        = '0;
        used_d      = '0;
        push_left_d = '0;
        dropping_d  = 1'b0;
        pending_d   = '0;
        active_d    = 1'b0;
        scan_done_d = '0;
        read_left_d = '0;
      end
      vrrl_pkg::ACT_LOAD_OUT: begin
        out_d     = res_q;
        out_vld_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      oldest_q    <= '0;
      wp_q        <= '0;
      scan_pos_q  <= '0;
      read_pos_q  <= '0;
      base_q      <= '0;
      used_q      <= '0;
      pending_q   <= '0;
      scan_done_q <= '0;
      walk_done_q <= '0;
      push_left_q <= '0;
      read_left_q <= '0;
      dropping_q  <= 1'b0;
      all_q       <= 1'b0;
      active_q    <= 1'b0;
      filter_q    <= '0;
      off_q       <= '0;
      cap_off_q   <= '0;
      cap_vld_q   <= 1'b0;
      count_q     <= '0;
    end else begin
      out_vld_q   <= out_vld_d;
      oldest_q    <= oldest_d;
      wp_q        <= wp_d;
      scan_pos_q  <= scan_pos_d;
      read_pos_q  <= read_pos_d;
      base_q      <= base_d;
      used_q      <= used_d;
      pending_q   <= pending_d;
      scan_done_q <= scan_done_d;
      walk_done_q <= walk_done_d;
      push_left_q <= push_left_d;
      read_left_q <= read_left_d;
      dropping_q  <= dropping_d;
      all_q       <= all_d;
      active_q    <= active_d;
      filter_q    <= filter_d;
      off_q       <= off_d;
      cap_off_q   <= off_q;
      cap_vld_q   <= (act_i == vrrl_pkg::ACT_HRD);
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    res_q     <= res_d;
    out_q     <= out_d;
    h_stamp_q <= h_stamp_d;
    h_id_q    <= h_id_d;
    h_len_q   <= h_len_d;
    h_level_q <= h_level_d;
    h_mark_q  <= h_mark_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

[hdl/variable_record_ring_log_core.sv]
// ----------------------------------------------------------------------------
// variable_record_ring_log_core
// Byte ring log of variable-length records with eviction, discard and scan.
// ----------------------------------------------------------------------------
// One item at a time, one result per item, through a single-port-read,
// single-port-write byte memory. A push start reads the header of each
// record that it evicts and then writes its own header, one byte per cycle
// for each header. Discard walks every live record; scan next steps over
// records until one matches or it runs out of records. A waiting result
// sits in the output register while the next item is taken; a result that
// finds the register still full holds its item at the last step until the
// register empties.
module variable_record_ring_log_core #(
  parameter int RING_BYTES          = 4096,
  parameter int RECORD_HEADER_BYTES = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  vrrl_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vrrl_pkg::out_item_t out_item_o
);

  vrrl_pkg::act_e     act;
  vrrl_pkg::dp_stat_t stat;

  vrrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .act_o      (act)
  );

  vrrl_dp #(
    .RING_BYTES          (RING_BYTES),
    .RECORD_HEADER_BYTES (RECORD_HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .act_i       (act),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hdl/vrrl_chk.sv]
// ----------------------------------------------------------------------------
// vrrl_chk
// Port-level checks for the ring log, bound to the top level.
// ----------------------------------------------------------------------------
module vrrl_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input vrrl_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input vrrl_pkg::out_item_t out_item_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_item_i))
    else $error("input item changed while waiting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while previous still in work");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != vrrl_pkg::ST_OK) |->
      (out_item_o.data_out == 8'd0) && !out_item_o.last_byte &&
      (out_item_o.evicted == 8'd0) && (out_item_o.length_out == '0))
    else $error("non-ok result carries payload");

  a_last_has_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last_byte |->
      (out_item_o.stamp_out == 64'd0) && (out_item_o.evicted == 8'd0))
    else $error("read byte result carries record fields");

endmodule

bind variable_record_ring_log_core vrrl_chk u_vrrl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

[test/tb_variable_record_ring_log_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_variable_record_ring_log_core
// Self-checking bench for the byte ring log: a directed table of pushes,
// discards, scans, reads and clears, then random record traffic, all checked
// item by item against a behavioural model of the ring held in the bench.
// ----------------------------------------------------------------------------
module tb_variable_record_ring_log_core;

  localparam int RING  = 4096;
  localparam int HDR   = 24;
  localparam int WDOG  = 40000;
  localparam int ITEMS = 1100;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  vrrl_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  vrrl_pkg::out_item_t out_item_o;

  variable_record_ring_log_core #(.RING_BYTES(RING), .RECORD_HEADER_BYTES(HDR)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ring model
  logic [7:0]  ring_mem [RING];
  int unsigned old_p, wr_p, used, push_rem, pend_sz, scan_p, scan_done, rd_p, rd_rem;
  bit          dropping, scan_all, scanning;
  logic [63:0] scan_id;

  vrrl_pkg::out_item_t expected_q [$];
  int          errors = 0;
  int          idle_pct = 28;
  int          quiet = 0;
  int unsigned n_sent = 0;
  bit          stim_done = 1'b0;
  logic [63:0] ids [4] = '{64'd0, 64'd1, 64'hffff_ffff_ffff_ffff, 64'h1234};

  function automatic logic [7:0] rb(int unsigned p);
    return ring_mem[p % RING];
  endfunction

  function automatic logic [63:0] rq(int unsigned p);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) v[8*i +: 8] = rb(p + i);
    return v;
  endfunction

  function automatic int unsigned rsize(int unsigned p);
    return HDR + {rb(p + vrrl_pkg::OFS_LEN_HI), rb(p + vrrl_pkg::OFS_LEN)};
  endfunction

  function automatic vrrl_pkg::out_item_t ring_log_step(vrrl_pkg::in_item_t it);
    vrrl_pkg::out_item_t r;
    int unsigned sz, cnt, rec, done;
    bit          hit;
    r = '0;
    r.status = vrrl_pkg::ST_OK;
    case (it.mode)
      vrrl_pkg::MODE_PUSH_START: begin
        sz = HDR + it.message_length;
        cnt = 0;
        if (push_rem != 0) r.status = vrrl_pkg::ST_IGNORED;
        else if (sz > RING) begin
          dropping = 1'b1; push_rem = it.message_length; r.status = vrrl_pkg::ST_TOO_BIG;
        end else begin
          while (RING - used < sz && used != 0) begin
            rec = rsize(old_p);
            if (rec > used) rec = used;
            old_p = (old_p + rec) % RING;
            used -= rec;
            if (cnt < 255) cnt++;
          end
          if (cnt != 0) begin scanning = 1'b0; rd_rem = 0; end
          for (int i = 0; i < HDR; i++) ring_mem[(wr_p + i) % RING] = 8'h00;
          for (int i = 0; i < 8; i++) begin
            ring_mem[(wr_p + i) % RING] = it.stamp[8*i +: 8];
            ring_mem[(wr_p + vrrl_pkg::OFS_ID + i) % RING] = it.run_id[8*i +: 8];
          end
          ring_mem[(wr_p + vrrl_pkg::OFS_LEN) % RING] = it.message_length[7:0];
          ring_mem[(wr_p + vrrl_pkg::OFS_LEN_HI) % RING] = {4'h0, it.message_length[11:8]};
          ring_mem[(wr_p + vrrl_pkg::OFS_LEVEL) % RING] = it.level;
          wr_p = (wr_p + HDR) % RING;
          if (it.message_length == 0) used += sz;
          else begin pend_sz = sz; push_rem = it.message_length; end
          r.evicted = cnt[7:0];
        end
      end
      vrrl_pkg::MODE_PUSH_BYTE: begin
        if (push_rem == 0) r.status = vrrl_pkg::ST_IGNORED;
        else if (dropping) begin
          push_rem--;
          if (push_rem == 0) dropping = 1'b0;
          r.status = vrrl_pkg::ST_TOO_BIG;
        end else begin
          ring_mem[wr_p] = it.data_in;
          wr_p = (wr_p + 1) % RING;
          push_rem--;
          if (push_rem == 0) used += pend_sz;
        end
      end
      vrrl_pkg::MODE_DISCARD: begin
        rec = old_p; done = 0;
        while (done < used) begin
          if (rq(rec + vrrl_pkg::OFS_ID) == it.run_id)
            ring_mem[(rec + vrrl_pkg::OFS_MARK) % RING] = 8'h01;
          done += rsize(rec);
          rec = (rec + rsize(rec)) % RING;
        end
      end
      vrrl_pkg::MODE_SCAN_BEGIN: begin
        scan_id = it.run_id; scan_all = it.select_all; scan_p = old_p;
        scan_done = 0; scanning = 1'b1; rd_rem = 0;
      end
      vrrl_pkg::MODE_SCAN_NEXT: begin
        if (!scanning) r.status = vrrl_pkg::ST_IGNORED;
        else begin
          hit = 1'b0;
          while (!hit && scan_done < used) begin
            rec = scan_p; sz = rsize(rec);
            scan_p = (rec + sz) % RING;
            scan_done += sz;
            if (rb(rec + vrrl_pkg::OFS_MARK) == 0 &&
                (scan_all || rq(rec + vrrl_pkg::OFS_ID) == scan_id)) begin
              hit = 1'b1;
              r.stamp_out = rq(rec);
              r.level_out = rb(rec + vrrl_pkg::OFS_LEVEL);
              r.length_out = 12'(sz - HDR);
              rd_p = (rec + HDR) % RING;
              rd_rem = sz - HDR;
              if (!scan_all) ring_mem[(rec + vrrl_pkg::OFS_MARK) % RING] = 8'h01;
            end
          end
          if (!hit) begin
            scanning = 1'b0; rd_rem = 0; r.status = vrrl_pkg::ST_ENDED;
          end
        end
      end
      vrrl_pkg::MODE_READ_BYTE: begin
        if (rd_rem == 0) r.status = vrrl_pkg::ST_ENDED;
        else begin
          r.data_out = ring_mem[rd_p];
          rd_p = (rd_p + 1) % RING;
          rd_rem--;
          r.last_byte = (rd_rem == 0);
        end
      end
      vrrl_pkg::MODE_CLEAR: begin
        old_p = 0; wr_p = 0; used = 0; push_rem = 0; dropping = 1'b0; pend_sz = 0;
        scanning = 1'b0; scan_done = 0; rd_rem = 0;
      end
      default: r.status = vrrl_pkg::ST_IGNORED;
    endcase
    return r;
  endfunction

  task automatic send_item(vrrl_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_q = {expected_q, ring_log_step(it)};
    n_sent++;
  endtask

  function automatic vrrl_pkg::in_item_t mk(logic [2:0] m, logic [11:0] len = 0,
                                            logic [63:0] id = 0, bit sel_all = 0);
    vrrl_pkg::in_item_t it;
    it = '0;
    it.mode = m;
    it.stamp = {$urandom, $urandom};
    it.run_id = id;
    it.level = 8'($urandom);
    it.message_length = len;
    it.data_in = 8'($urandom);
    it.select_all = sel_all;
    return it;
  endfunction

  // result checking
  always @(posedge clk_i) begin
    vrrl_pkg::out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item %h", out_item_o); errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_item_o.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_item_o.status); errors++; end
          if (out_item_o.stamp_out !== e.stamp_out) begin
            $error("stamp_out exp %h got %h", e.stamp_out, out_item_o.stamp_out); errors++; end
          if (out_item_o.level_out !== e.level_out) begin
            $error("level_out exp %h got %h", e.level_out, out_item_o.level_out); errors++; end
          if (out_item_o.length_out !== e.length_out) begin
            $error("length_out exp %0d got %0d", e.length_out, out_item_o.length_out);
            errors++; end
          if (out_item_o.data_out !== e.data_out) begin
            $error("data_out exp %h got %h", e.data_out, out_item_o.data_out); errors++; end
          if (out_item_o.last_byte !== e.last_byte) begin
            $error("last_byte exp %b got %b", e.last_byte, out_item_o.last_byte); errors++; end
          if (out_item_o.evicted !== e.evicted) begin
            $error("evicted exp %0d got %0d", e.evicted, out_item_o.evicted); errors++; end
        end
      end
      out_ready_i <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
    else if (!stim_done || expected_q.size() != 0) begin
      quiet <= quiet + 1;
      if (quiet >= WDOG) begin
        $display("FAIL variable_record_ring_log_core");
        $finish;
      end
    end
  end

  typedef struct {
    vrrl_pkg::in_item_t it;
    bit                 chk;
    logic [1:0]         st;
  } dir_row_t;

  dir_row_t            dir_tbl [$];
  vrrl_pkg::out_item_t dir_exp;

  function automatic dir_row_t row(vrrl_pkg::in_item_t it, bit chk = 0,
                                   logic [1:0] st = vrrl_pkg::ST_OK);
    dir_row_t d;
    d.it = it; d.chk = chk; d.st = st;
    return d;
  endfunction

  initial begin
    vrrl_pkg::in_item_t it;
    int unsigned len;
    old_p = 0; wr_p = 0; used = 0; push_rem = 0; pend_sz = 0; dropping = 1'b0;
    scan_p = 0; scan_done = 0; scanning = 1'b0; scan_all = 1'b0; scan_id = '0;
    rd_p = 0; rd_rem = 0;
    for (int i = 0; i < RING; i++) ring_mem[i] = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle-state errors, too large, extremes, every mode
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_SCAN_NEXT), 1, vrrl_pkg::ST_IGNORED)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_READ_BYTE), 1, vrrl_pkg::ST_ENDED)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_BYTE), 1, vrrl_pkg::ST_IGNORED)};
    dir_tbl = {dir_tbl, row(mk(3'd7), 1, vrrl_pkg::ST_IGNORED)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_START, 12'd4072))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_START, 12'd4073, '1), 1,
                            vrrl_pkg::ST_IGNORED)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_CLEAR), 1, vrrl_pkg::ST_OK)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_START, 12'd4073, '1), 1,
                            vrrl_pkg::ST_TOO_BIG)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_BYTE), 1, vrrl_pkg::ST_TOO_BIG)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_CLEAR), 1, vrrl_pkg::ST_OK)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_BYTE), 1, vrrl_pkg::ST_IGNORED)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_START, 12'd0, '1))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_START, 12'd2, 64'd0))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_START, 12'd1), 1, vrrl_pkg::ST_IGNORED)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_BYTE))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_BYTE))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_SCAN_BEGIN, 12'd0, 64'd0, 1'b1))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_SCAN_NEXT))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_READ_BYTE), 1, vrrl_pkg::ST_ENDED)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_SCAN_NEXT))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_READ_BYTE))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_READ_BYTE))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_READ_BYTE), 1, vrrl_pkg::ST_ENDED)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_SCAN_NEXT), 1, vrrl_pkg::ST_ENDED)};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_DISCARD, 12'd0, '1))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_SCAN_BEGIN, 12'd0, 64'd0, 1'b0))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_SCAN_NEXT))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_SCAN_NEXT), 1, vrrl_pkg::ST_ENDED)};
    // full-size record evicts everything, then is abandoned
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_PUSH_START, 12'd4072, '1))};
    dir_tbl = {dir_tbl, row(mk(vrrl_pkg::MODE_CLEAR), 1, vrrl_pkg::ST_OK)};
    foreach (dir_tbl[i]) begin
      send_item(dir_tbl[i].it);
      dir_exp = expected_q[$];
      if (dir_tbl[i].chk && dir_exp.status !== dir_tbl[i].st) begin
        $error("table row %0d: status exp %0d predicted %0d", i, dir_tbl[i].st, dir_exp.status);
        errors++;
      end
    end

    // header-only records fill the ring and wrap it
    for (int i = 0; i < 180; i++)
      send_item(mk(vrrl_pkg::MODE_PUSH_START, 12'd0, ids[$urandom_range(3)]));

    // sender holds off until all results are in
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);

    while (n_sent < ITEMS) begin
      if (n_sent > 500 && n_sent < 700) idle_pct = 0;
      else idle_pct = 28;
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          len = ($urandom_range(39) == 0) ? $urandom_range(4095) : $urandom_range(24);
          it = mk(vrrl_pkg::MODE_PUSH_START, 12'(len), ids[$urandom_range(3)]);
          if ($urandom_range(3) == 0) it.stamp = '1;
          send_item(it);
          if (len > 40) begin
            repeat ($urandom_range(8)) send_item(mk(vrrl_pkg::MODE_PUSH_BYTE));
            send_item(mk(vrrl_pkg::MODE_CLEAR));
          end else if ($urandom_range(9) != 0) begin
            for (int i = 0; i < len; i++) send_item(mk(vrrl_pkg::MODE_PUSH_BYTE));
          end
        end
        4: send_item(mk(vrrl_pkg::MODE_DISCARD, 12'd0, ids[$urandom_range(3)]));
        5, 6, 7: begin
          send_item(mk(vrrl_pkg::MODE_SCAN_BEGIN, 12'd0, ids[$urandom_range(3)],
                       1'($urandom_range(1))));
          repeat ($urandom_range(3)) begin
            send_item(mk(vrrl_pkg::MODE_SCAN_NEXT));
            repeat ($urandom_range(4)) send_item(mk(vrrl_pkg::MODE_READ_BYTE));
          end
        end
        8: begin
          it = mk(3'($urandom_range(7)), 12'($urandom_range(4095)), {$urandom, $urandom},
                  1'($urandom_range(1)));
          if (it.mode == vrrl_pkg::MODE_PUSH_START) it.message_length = 12'($urandom_range(60));
          send_item(it);
        end
        default: begin
          if ($urandom_range(15) == 0) send_item(mk(vrrl_pkg::MODE_CLEAR));
          else send_item(mk(vrrl_pkg::MODE_READ_BYTE));
        end
      endcase
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("PASS variable_record_ring_log_core");
    else $display("FAIL variable_record_ring_log_core");
    $finish;
  end
endmodule
